/* src/euler_to_quaternion_top_defines.svh */
// assertion macros used by the top-level rtl file
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define EQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EQ_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define EQ_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* src/euq_pkg.sv */
`timescale 1ns / 1ps
package euq_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int ANGLE_DROP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
	localparam logic [15:0] ANGLE_MASK = 16'hFFFF << ANGLE_DROP;
	localparam logic signed [31:0] GAIN_Q30 = 32'sh26DD3B6A;
	// cordic lanes, pair product, triple products, output
	localparam int NSTAGE = STEPS + 3;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	// atan(2^-i) with pi = 2^31
	function automatic logic signed [31:0] atan_q(input int i);
		logic signed [31:0] r;
		case (i)
			0: r = 32'sh20000000;
			1: r = 32'sh12E4051E;
			2: r = 32'sh09FB385B;
			3: r = 32'sh051111D4;
			4: r = 32'sh028B0D43;
			5: r = 32'sh0145D7E1;
			6: r = 32'sh00A2F61E;
			7: r = 32'sh00517C55;
			8: r = 32'sh0028BE53;
			9: r = 32'sh00145F2F;
			10: r = 32'sh000A2F98;
			11: r = 32'sh000517CC;
			12: r = 32'sh00028BE6;
			13: r = 32'sh000145F3;
			14: r = 32'sh0000A2FA;
			15: r = 32'sh0000517D;
			16: r = 32'sh000028BE;
			17: r = 32'sh0000145F;
			18: r = 32'sh00000A30;
			19: r = 32'sh00000518;
			20: r = 32'sh0000028C;
			21: r = 32'sh00000146;
			22: r = 32'sh000000A3;
			23: r = 32'sh00000051;
			24: r = 32'sh00000029;
			25: r = 32'sh00000014;
			26: r = 32'sh0000000A;
			27: r = 32'sh00000005;
			28: r = 32'sh00000003;
			29: r = 32'sh00000001;
			30: r = 32'sh00000001;
			default: r = 32'sh00000000;
		endcase
		return r;
	endfunction
endpackage

/* src/euq_cordic.sv */
`timescale 1ns / 1ps
module euq_cordic (
	input  logic                          clk,
	input  logic [euq_pkg::STEPS-1:0]     ld,
	input  logic signed [15:0]            angle,
	output logic signed [31:0]            cos_q,
	output logic signed [31:0]            sin_q
);
	import euq_pkg::*;

	logic signed [31:0] x_s [STEPS];
	logic signed [31:0] y_s [STEPS];
	logic signed [33:0] z_s [STEPS];

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_step
			logic signed [31:0] xi, yi;
			logic signed [33:0] zi;
			logic signed [33:0] t;
			// step input: first step starts from the gain and the half angle
			if (k == 0) begin : g_first
				assign xi = GAIN_Q30;
				assign yi = '0;
				assign zi = {{3{angle[15]}}, angle, 15'b0};
			end else begin : g_next
				assign xi = x_s[k-1];
				assign yi = y_s[k-1];
				assign zi = z_s[k-1];
			end
			assign t = {2'b00, atan_q(k)};
			// one micro-rotation per stage
			always_ff @(posedge clk) begin
				if (ld[k]) begin
					if (!zi[33]) begin
						x_s[k] <= xi - (yi >>> k);
						y_s[k] <= yi + (xi >>> k);
						z_s[k] <= zi - t;
					end else begin
						x_s[k] <= xi + (yi >>> k);
						y_s[k] <= yi - (xi >>> k);
						z_s[k] <= zi + t;
					end
				end
			end
		end
	endgenerate

	assign cos_q = x_s[STEPS-1];
	assign sin_q = y_s[STEPS-1];
endmodule

/* src/euler_to_quaternion_top.sv */
// STEPS + 3 register stages (19 with 16 cordic steps); quat valid rises when a sample
// reaches the output stage; throughput: one sample per cycle while sample_stall is low;
// a stage holds while its successor is full and held, so bubbles are squeezed out and
// the input stalls only when every stage is full and quat_stall is high
// reset: arst_n clears all stage valid bits asynchronously; data registers are not reset
`timescale 1ns / 1ps
`include "euler_to_quaternion_top_defines.svh"
module euler_to_quaternion_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  euq_pkg::sample_t sample,
	output logic             quat_valid,
	input  logic             quat_stall,
	output euq_pkg::quat_t   quat
);
	import euq_pkg::*;

	logic [NSTAGE-1:0] v_q;
	logic [NSTAGE-1:0] rdy;
	logic [NSTAGE-1:0] vin;

	// stage ready chain
	always_comb begin
		rdy[NSTAGE-1] = !v_q[NSTAGE-1] || !quat_stall;
		for (int i = NSTAGE - 2; i >= 0; i--) begin
			rdy[i] = !v_q[i] || rdy[i+1];
		end
		vin = {v_q[NSTAGE-2:0], sample_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NSTAGE; i++) begin
				if (rdy[i]) v_q[i] <= vin[i];
			end
		end
	end

	assign sample_stall = !rdy[0];
	assign quat_valid = v_q[NSTAGE-1];

	// half-angle cos/sin lanes
	logic signed [31:0] cr, sr, cp, sp, cy, sy;
	logic signed [15:0] ra, pa, ya;
	assign ra = sample.roll_angle & ANGLE_MASK;
	assign pa = sample.pitch_angle & ANGLE_MASK;
	assign ya = sample.yaw_angle & ANGLE_MASK;

	euq_cordic u_roll (.clk(clk), .ld(rdy[STEPS-1:0]), .angle(ra), .cos_q(cr), .sin_q(sr));
	euq_cordic u_pitch (.clk(clk), .ld(rdy[STEPS-1:0]), .angle(pa), .cos_q(cp), .sin_q(sp));
	euq_cordic u_yaw (.clk(clk), .ld(rdy[STEPS-1:0]), .angle(ya), .cos_q(cy), .sin_q(sy));

	// pair products, rounded back to q30
	logic signed [63:0] p_crcp, p_srsp, p_crsp, p_srcp;
	logic signed [31:0] crcp_s1, srsp_s1, crsp_s1, srcp_s1, cy_s1, sy_s1;
	localparam logic signed [63:0] HALF_Q30 = 64'sd1 <<< 29;
	assign p_crcp = 64'(cr) * 64'(cp) + HALF_Q30;
	assign p_srsp = 64'(sr) * 64'(sp) + HALF_Q30;
	assign p_crsp = 64'(cr) * 64'(sp) + HALF_Q30;
	assign p_srcp = 64'(sr) * 64'(cp) + HALF_Q30;

	always_ff @(posedge clk) begin
		if (rdy[STEPS]) begin
			crcp_s1 <= p_crcp[61:30];
			srsp_s1 <= p_srsp[61:30];
			crsp_s1 <= p_crsp[61:30];
			srcp_s1 <= p_srcp[61:30];
			cy_s1 <= cy;
			sy_s1 <= sy;
		end
	end

	// triple products in q60
	logic signed [63:0] t0_s2, t1_s2, t2_s2, t3_s2, t4_s2, t5_s2, t6_s2, t7_s2;
	always_ff @(posedge clk) begin
		if (rdy[STEPS+1]) begin
			t0_s2 <= 64'(crcp_s1) * 64'(cy_s1);
			t1_s2 <= 64'(srsp_s1) * 64'(sy_s1);
			t2_s2 <= 64'(srcp_s1) * 64'(cy_s1);
			t3_s2 <= 64'(crsp_s1) * 64'(sy_s1);
			t4_s2 <= 64'(crsp_s1) * 64'(cy_s1);
			t5_s2 <= 64'(srcp_s1) * 64'(sy_s1);
			t6_s2 <= 64'(crcp_s1) * 64'(sy_s1);
			t7_s2 <= 64'(srsp_s1) * 64'(cy_s1);
		end
	end

	// combine, round to q15 and saturate
	function automatic logic signed [15:0] to_q15(input logic signed [64:0] s);
		logic signed [64:0] r;
		logic signed [19:0] h;
		logic signed [15:0] o;
		r = s + (65'sd1 <<< 44);
		h = r[64:45];
		if (h > 20'sd32767) o = 16'sh7FFF;
		else if (h < -20'sd32768) o = 16'sh8000;
		else o = h[15:0];
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (rdy[STEPS+2]) begin
			quat.quat_w <= to_q15(65'(t0_s2) + 65'(t1_s2));
			quat.quat_x <= to_q15(65'(t2_s2) - 65'(t3_s2));
			quat.quat_y <= to_q15(65'(t4_s2) + 65'(t5_s2));
			quat.quat_z <= to_q15(65'(t6_s2) - 65'(t7_s2));
		end
	end

	// input stalls only when the output is full and held
	`EQ_ASSERT(a_stall_src, clk, arst_n, sample_stall |-> (quat_valid && quat_stall), "input stall without output stall")
	// a new result comes from the stage before the output
	`EQ_ASSERT(a_out_src, clk, arst_n, $rose(quat_valid) |-> $past(v_q[NSTAGE-2]), "output valid from nowhere")
	// a waiting item moves into the output on transfer
	`EQ_ASSERT(a_refill, clk, arst_n, (quat_valid && !quat_stall && v_q[NSTAGE-2]) |=> quat_valid, "item lost at output")
	// a full stage with a free successor must move on
	`EQ_NEVER(a_no_hold, clk, arst_n, v_q[STEPS] && !v_q[STEPS+1] && !rdy[STEPS], "stage blocked by empty successor")
endmodule
